// File: hdl/qoi_pkg.sv
// Shared types, constants and the header byte table for the YUV-fed QOI encoder.
// Used by every module of the block except qoi_ram; depends on nothing.
`default_nettype none

package qoi_pkg;

  // Index table geometry
  localparam int unsigned IDX_DEPTH = 64;
  localparam int unsigned IDX_AW    = 6;

  // Op codes and limits of the encoded stream
  localparam logic [7:0] OP_DIFF  = 8'h40;
  localparam logic [7:0] OP_LUMA  = 8'h80;
  localparam logic [7:0] OP_RUN   = 8'hC0;
  localparam logic [7:0] OP_RGB   = 8'hFE;
  localparam logic [5:0] RUN_CAP  = 6'd62;
  localparam int unsigned HASH_BIAS = 255 * 11;

  // Frame framing sizes
  localparam logic [3:0] HDR_LAST = 4'd13;
  localparam logic [3:0] TRL_LAST = 4'd7;
  localparam logic [7:0] TRL_END  = 8'h01;

  // Configuration register map
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [15:0] IMAGE_WIDTH_RST  = 16'd320;
  localparam logic [15:0] IMAGE_HEIGHT_RST = 16'd240;

  // One input word: a sampled pixel
  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] chroma_u;
    logic [7:0] chroma_v;
    logic       end_of_frame;
  } pix_in_t;

  // One output word: a stream byte
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_item;
    logic       end_of_stream;
  } code_out_t;

  // Work for the byte sequencer: header, up to five body bytes, trailer
  typedef struct packed {
    logic            hdr;
    logic            eof;
    logic [2:0]      body_n;
    logic [4:0][7:0] body;
  } cmd_t;

  // Header byte at a given position: magic, width, height, channels, colorspace
  function automatic logic [7:0] hdr_byte(input logic [3:0] idx, input logic [15:0] w,
                                          input logic [15:0] h);
    logic [7:0] b;
    unique case (idx)
      4'd0:    b = 8'h71;
      4'd1:    b = 8'h6F;
      4'd2:    b = 8'h69;
      4'd3:    b = 8'h66;
      4'd6:    b = w[15:8];
      4'd7:    b = w[7:0];
      4'd10:   b = h[15:8];
      4'd11:   b = h[7:0];
      4'd12:   b = 8'h03;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// File: hdl/qoi_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module qoi_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, returns old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hdl/qoi_front.sv
// Front end: YUV to RGB conversion pipeline and per-pixel op classification.
// Depends on qoi_pkg and qoi_ram (index table colours).
`default_nettype none

module qoi_front import qoi_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    pix_valid,
  output logic         pix_ready,
  input  wire pix_in_t pix,
  output logic         cmd_push,
  output cmd_t         cmd,
  input  wire logic    cmd_full
);

  localparam int unsigned PW = 20;
  typedef logic signed [PW-1:0] acc_t;

  // Clamp a fixed-point sum to 0..255 after dropping eight fraction bits
  function automatic logic [7:0] clamp8(input acc_t s);
    logic [7:0] q;
    if (s[PW-1]) begin
      q = 8'd0;
    end else if (s[PW-2:16] != '0) begin
      q = 8'hFF;
    end else begin
      q = s[15:8];
    end
    return q;
  endfunction

  // Stage 1: centered samples and coefficient products
  acc_t cy, cu, cv;
  logic s1_v, s1_eof;
  acc_t s1_y, s1_rv, s1_gu, s1_gv, s1_bu;
  // Stage 2: clamped RGB
  acc_t sum_r, sum_g, sum_b;
  logic        s2_v, s2_eof;
  logic [23:0] s2_rgb;
  logic [12:0] hsum;
  logic [IDX_AW-1:0] s2_h;
  // Stage 3: classify against prior pixel, run and index table
  logic        s3_v, s3_eof;
  logic [23:0] s3_rgb;
  logic [IDX_AW-1:0] s3_h;
  logic [23:0] ram_rdata;
  logic        byp_v;
  logic [IDX_AW-1:0] byp_h;
  logic [23:0] byp_rgb;
  // Frame state
  logic        in_frame;
  logic [23:0] prior_rgb;
  logic [5:0]  run_len;
  logic [IDX_DEPTH-1:0] idx_valid, idx_valid_next;
  // Flow control
  logic s1_free, s2_free, s3_free, s3_commit, ram_re;
  // Classification results
  logic        fs, eq, hit, has_out, idx_we;
  logic [23:0] prior, idx_data;
  logic [5:0]  run, run_inc, run_next;
  logic signed [8:0] dr, dg, db;
  logic signed [9:0] rg, bg;
  logic [3:0][7:0] op;
  logic [2:0]  op_n;
  cmd_t        cmd_c;

  // Pipeline handshake
  assign s3_free   = !s3_v || s3_commit;
  assign s2_free   = !s2_v || s3_free;
  assign s1_free   = !s1_v || s2_free;
  assign pix_ready = s1_free;
  assign ram_re    = s2_v && s3_free;

  // Center samples and form products
  assign cy = acc_t'({1'b0, pix.luma}) - acc_t'(16);
  assign cu = acc_t'({1'b0, pix.chroma_u}) - acc_t'(128);
  assign cv = acc_t'({1'b0, pix.chroma_v}) - acc_t'(128);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (s1_free) begin
      s1_v <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && pix_valid) begin
      s1_y   <= cy * acc_t'(298);
      s1_rv  <= cv * acc_t'(409);
      s1_gu  <= cu * acc_t'(100);
      s1_gv  <= cv * acc_t'(208);
      s1_bu  <= cu * acc_t'(516);
      s1_eof <= pix.end_of_frame;
    end
  end

  // Sum, round and clamp each channel
  assign sum_r = s1_y + s1_rv + acc_t'(128);
  assign sum_g = s1_y - s1_gu - s1_gv + acc_t'(128);
  assign sum_b = s1_y + s1_bu + acc_t'(128);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (s2_free) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free && s1_v) begin
      s2_rgb <= {clamp8(sum_r), clamp8(sum_g), clamp8(sum_b)};
      s2_eof <= s1_eof;
    end
  end

  // Hash the colour and fetch its index entry on the way into stage 3
  assign hsum = 13'(s2_rgb[23:16]) * 13'd3 + 13'(s2_rgb[15:8]) * 13'd5
              + 13'(s2_rgb[7:0]) * 13'd7 + 13'(HASH_BIAS);
  assign s2_h = hsum[IDX_AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (s3_free) begin
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      s3_rgb <= s2_rgb;
      s3_h   <= s2_h;
      s3_eof <= s2_eof;
    end
  end

  qoi_ram #(
    .WIDTH (24),
    .DEPTH (IDX_DEPTH)
  ) u_idx_ram (
    .clk   (clk),
    .we    (idx_we),
    .waddr (s3_h),
    .wdata (s3_rgb),
    .re    (ram_re),
    .raddr (s2_h),
    .rdata (ram_rdata)
  );

  // Classify the pixel and build its byte list
  always_comb begin
    fs       = !in_frame;
    prior    = fs ? 24'd0 : prior_rgb;
    run      = fs ? 6'd0 : run_len;
    run_inc  = run + 6'd1;
    eq       = (s3_rgb == prior);
    idx_data = (byp_v && byp_h == s3_h) ? byp_rgb : ram_rdata;
    hit      = !fs && idx_valid[s3_h] && (idx_data == s3_rgb);

    dr = signed'({1'b0, s3_rgb[23:16]}) - signed'({1'b0, prior[23:16]});
    dg = signed'({1'b0, s3_rgb[15:8]})  - signed'({1'b0, prior[15:8]});
    db = signed'({1'b0, s3_rgb[7:0]})   - signed'({1'b0, prior[7:0]});
    rg = 10'(dr) - 10'(dg);
    bg = 10'(db) - 10'(dg);

    op   = '0;
    op_n = 3'd0;
    if (hit) begin
      op[0] = {2'b00, s3_h};
      op_n  = 3'd1;
    end else if (dr >= -9'sd2 && dr <= 9'sd1 && dg >= -9'sd2 && dg <= 9'sd1 &&
                 db >= -9'sd2 && db <= 9'sd1) begin
      op[0] = OP_DIFF | {2'b00, 2'(dr + 9'sd2), 2'(dg + 9'sd2), 2'(db + 9'sd2)};
      op_n  = 3'd1;
    end else if (dg >= -9'sd32 && dg <= 9'sd31 && rg >= -10'sd8 && rg <= 10'sd7 &&
                 bg >= -10'sd8 && bg <= 10'sd7) begin
      op[0] = OP_LUMA | {2'b00, 6'(dg + 9'sd32)};
      op[1] = {4'(rg + 10'sd8), 4'(bg + 10'sd8)};
      op_n  = 3'd2;
    end else begin
      op[0] = OP_RGB;
      op[1] = s3_rgb[23:16];
      op[2] = s3_rgb[15:8];
      op[3] = s3_rgb[7:0];
      op_n  = 3'd4;
    end

    cmd_c     = '0;
    cmd_c.hdr = fs;
    cmd_c.eof = s3_eof;
    run_next  = 6'd0;
    if (eq) begin
      // Extend the run; close it at the cap or at end of frame
      if (run_inc == RUN_CAP) begin
        cmd_c.body[0] = OP_RUN | {2'b00, RUN_CAP - 6'd1};
        cmd_c.body_n  = 3'd1;
      end else if (s3_eof) begin
        cmd_c.body[0] = OP_RUN | {2'b00, run};
        cmd_c.body_n  = 3'd1;
      end else begin
        run_next = run_inc;
      end
    end else if (run != 6'd0) begin
      // Flush the pending run ahead of the op
      cmd_c.body[0]   = OP_RUN | {2'b00, run - 6'd1};
      cmd_c.body[4:1] = op;
      cmd_c.body_n    = op_n + 3'd1;
    end else begin
      cmd_c.body[3:0] = op;
      cmd_c.body_n    = op_n;
    end

    has_out   = fs || s3_eof || (cmd_c.body_n != 3'd0);
    s3_commit = s3_v && (!has_out || !cmd_full);
    cmd_push  = s3_v && has_out && !cmd_full;
    idx_we    = s3_commit && !eq && !hit;

    idx_valid_next = fs ? '0 : idx_valid;
    if (idx_we) begin
      idx_valid_next[s3_h] = 1'b1;
    end
  end

  assign cmd = cmd_c;

  // Commit frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame  <= 1'b0;
      prior_rgb <= '0;
      run_len   <= '0;
      idx_valid <= '0;
      byp_v     <= 1'b0;
    end else if (s3_commit) begin
      in_frame  <= !s3_eof;
      prior_rgb <= eq ? prior : s3_rgb;
      run_len   <= run_next;
      idx_valid <= idx_valid_next;
      if (idx_we) begin
        byp_v <= 1'b1;
      end
    end
  end

  // Hold the last table write for a read that raced it
  always_ff @(posedge clk) begin
    if (idx_we) begin
      byp_h   <= s3_h;
      byp_rgb <= s3_rgb;
    end
  end

  a_eof_ends_frame: assert property (@(posedge clk) disable iff (rst)
    s3_commit && s3_eof |=> !in_frame)
    else $error("frame still open after end-of-frame pixel");

  a_write_marks_valid: assert property (@(posedge clk) disable iff (rst)
    idx_we |=> idx_valid[$past(s3_h)])
    else $error("index entry written but not marked valid");

endmodule

`default_nettype wire

// File: hdl/qoi_cmd_fifo.sv
// Short command queue between classification and the byte sequencer.
// Depends on qoi_pkg for the command type.
`default_nettype none

module qoi_cmd_fifo import qoi_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_data,
  output logic      full,
  input  wire logic pop,
  output logic      head_valid,
  output cmd_t      head
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  // Store entry
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("pop from empty command queue");

endmodule

`default_nettype wire

// File: hdl/qoi_back.sv
// Back end: walks each command through header, body and trailer bytes.
// Depends on qoi_pkg; drives the registered output channel.
`default_nettype none

module qoi_back import qoi_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        head_valid,
  input  wire cmd_t        head,
  output logic             pop,
  input  wire logic [15:0] image_width,
  input  wire logic [15:0] image_height,
  output logic             code_valid,
  input  wire logic        code_ready,
  output code_out_t        code
);

  typedef enum logic [3:0] {
    ST_START = 4'b0001,
    ST_HDR   = 4'b0010,
    ST_BODY  = 4'b0100,
    ST_TRL   = 4'b1000
  } seq_st_t;

  seq_st_t    st, first_st, cur_st, nxt_st;
  logic [3:0] cnt, cur_cnt;
  logic [7:0] body_b, cur_b;
  logic       done, emit;

  // Pick the opening phase of a fresh command
  always_comb begin
    if (head.hdr) begin
      first_st = ST_HDR;
    end else if (head.body_n != 3'd0) begin
      first_st = ST_BODY;
    end else begin
      first_st = ST_TRL;
    end
    cur_st  = (st == ST_START) ? first_st : st;
    cur_cnt = (st == ST_START) ? 4'd0 : cnt;
  end

  // Body byte select
  always_comb begin
    unique case (cur_cnt[2:0])
      3'd0:    body_b = head.body[0];
      3'd1:    body_b = head.body[1];
      3'd2:    body_b = head.body[2];
      3'd3:    body_b = head.body[3];
      3'd4:    body_b = head.body[4];
      default: body_b = 8'h00;
    endcase
  end

  // Current byte and the position after it
  always_comb begin
    cur_b  = 8'h00;
    nxt_st = cur_st;
    done   = 1'b0;
    unique case (cur_st)
      ST_HDR: begin
        cur_b = hdr_byte(cur_cnt, image_width, image_height);
        if (cur_cnt == HDR_LAST) begin
          if (head.body_n != 3'd0) begin
            nxt_st = ST_BODY;
          end else if (head.eof) begin
            nxt_st = ST_TRL;
          end else begin
            done = 1'b1;
          end
        end
      end
      ST_BODY: begin
        cur_b = body_b;
        if (cur_cnt[2:0] == head.body_n - 3'd1) begin
          if (head.eof) begin
            nxt_st = ST_TRL;
          end else begin
            done = 1'b1;
          end
        end
      end
      ST_TRL: begin
        cur_b = (cur_cnt == TRL_LAST) ? TRL_END : 8'h00;
        done  = (cur_cnt == TRL_LAST);
      end
      default: begin
        cur_b = 8'h00;
      end
    endcase
  end

  assign emit = head_valid && (!code_valid || code_ready);
  assign pop  = emit && done;

  // Advance the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= ST_START;
      cnt <= 4'd0;
    end else if (emit) begin
      if (done) begin
        st  <= ST_START;
        cnt <= 4'd0;
      end else if (nxt_st != cur_st) begin
        st  <= nxt_st;
        cnt <= 4'd0;
      end else begin
        st  <= cur_st;
        cnt <= cur_cnt + 4'd1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      code_valid <= 1'b0;
    end else if (emit) begin
      code_valid <= 1'b1;
    end else if (code_ready) begin
      code_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      code.out_byte      <= cur_b;
      code.last_of_item  <= done;
      code.end_of_stream <= done && (cur_st == ST_TRL);
    end
  end

  a_eos_is_last: assert property (@(posedge clk) disable iff (rst)
    code_valid && code.end_of_stream |-> code.last_of_item)
    else $error("end of stream not on the last byte of its pixel");

  a_pop_on_final: assert property (@(posedge clk) disable iff (rst)
    pop |=> code_valid && code.last_of_item)
    else $error("command dropped before its final byte");

endmodule

`default_nettype wire

// File: hdl/qoi_encoder_from_yuv.sv
// Path: the first byte of a pixel passes the three conversion/classify stages, the queue
// write and the output register.
// Throughput: one pixel per cycle in while the command queue has room, one byte per cycle
// out while code_ready is high. A pixel causes 0 to 5 bytes for run flush and op (4 for a
// full RGB op), plus 14 header bytes on a frame's first pixel and 8 trailer bytes on its last.
// Reset (rst, synchronous): pipeline, queue and frame state empty; width 320, height 240.
`default_nettype none

module qoi_encoder_from_yuv import qoi_pkg::*; #(
  parameter int unsigned CMD_DEPTH = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 pix_valid,
  output logic                      pix_ready,
  input  wire pix_in_t              pix,
  output logic                      code_valid,
  input  wire logic                 code_ready,
  output code_out_t                 code,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]          cfg_data
);

  logic [15:0] image_width, image_height;
  logic        cmd_push, cmd_full, cmd_pop, head_valid;
  cmd_t        cmd, head;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= IMAGE_WIDTH_RST;
      image_height <= IMAGE_HEIGHT_RST;
    end else if (cfg_valid) begin
      if (cfg_index == REG_IMAGE_WIDTH) begin
        image_width <= cfg_data;
      end else if (cfg_index == REG_IMAGE_HEIGHT) begin
        image_height <= cfg_data;
      end
    end
  end

  qoi_front u_front (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix       (pix),
    .cmd_push  (cmd_push),
    .cmd       (cmd),
    .cmd_full  (cmd_full)
  );

  qoi_cmd_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (cmd_push),
    .push_data  (cmd),
    .full       (cmd_full),
    .pop        (cmd_pop),
    .head_valid (head_valid),
    .head       (head)
  );

  qoi_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (cmd_pop),
    .image_width  (image_width),
    .image_height (image_height),
    .code_valid   (code_valid),
    .code_ready   (code_ready),
    .code         (code)
  );

endmodule

`default_nettype wire
